FILE: sv/tmtb_pkg.sv
// Shared types and constants for the text-mode terminal character buffer.
`timescale 1ns / 1ps

package tmtb_pkg;

  // Screen geometry, tied to the 5-bit row and column fields
  localparam int ROWS   = 24;
  localparam int COLS   = 32;
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = 5;
  localparam int COL_W  = 5;

  localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLS - 1);
  localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] SHIFT_CELLS = ADDR_W'(CELLS - COLS);
  localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(COLS);

  // Character codes and reset values
  localparam logic [7:0] BLANK        = 8'd32;
  localparam logic [7:0] NEWLINE      = 8'd10;
  localparam logic [7:0] COLOR_RESET  = 8'd100;
  localparam logic [7:0] PERIOD_RESET = 8'd25;

  // Command codes
  localparam logic [3:0] OP_PRINT  = 4'd0;
  localparam logic [3:0] OP_LEFT   = 4'd1;
  localparam logic [3:0] OP_RIGHT  = 4'd2;
  localparam logic [3:0] OP_UP     = 4'd3;
  localparam logic [3:0] OP_DOWN   = 4'd4;
  localparam logic [3:0] OP_SET    = 4'd5;
  localparam logic [3:0] OP_DELETE = 4'd6;
  localparam logic [3:0] OP_CLEAR  = 4'd7;
  localparam logic [3:0] OP_READ   = 4'd8;
  localparam logic [3:0] OP_TICK   = 4'd9;

  typedef struct packed {
    logic [3:0]       op;
    logic [7:0]       char_code;
    logic [ROW_W-1:0] row_arg;
    logic [COL_W-1:0] col_arg;
    logic             is_tick;
  } cmd_t;

  typedef struct packed {
    logic [7:0]       cell_char;
    logic [7:0]       cell_color;
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_col;
    logic             blink_on;
    logic             wrote_cell;
  } res_t;

  // Linear cell address of a row and column
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(row) * ROW_STRIDE + ADDR_W'(col);
  endfunction

endpackage

FILE: sv/tmtb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module tmtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/text_mode_terminal_buffer_unit.sv
// Text-mode terminal buffer: 24 x 32 cells of character and colour, cursor and blink.
// A result is registered after its request; read-cell's data passes first through
// the registered read port of the cell RAMs.
// Throughput: one request a cycle for prints, moves, ticks and set while the output is
// not stalled; read-cell, a scroll (one cell copied per cycle) and clear block requests.
// Reset: synchronous, active low; a clearing pass blanks every cell of both planes
// before the first request is taken. Configuration writes are taken at any time.
`timescale 1ns / 1ps

module text_mode_terminal_buffer_unit import tmtb_pkg::*; #(
  parameter int COLOR_ESCAPE_BASE = 240
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  cmd_t       in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output res_t       out_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  localparam logic [7:0] ESC_LO = 8'(COLOR_ESCAPE_BASE);
  localparam logic [7:0] ESC_HI = 8'(COLOR_ESCAPE_BASE + 15);

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RD     = 3'd1;
  localparam logic [2:0] ST_SCROLL = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_CLEAR  = 3'd4;

  logic [2:0]        state_r;
  logic [ADDR_W-1:0] idx_r;
  logic [ADDR_W-1:0] wa_r;
  logic              wv_r;
  logic              wblank_r;
  logic [ROW_W-1:0]  cur_row_r, row_nxt;
  logic [COL_W-1:0]  cur_col_r, col_nxt;
  logic [7:0]        color_r, color_nxt;
  logic              blink_r, blink_nxt;
  logic [7:0]        count_r, count_nxt;
  logic [7:0]        period_r;
  logic              out_valid_r;
  res_t              out_data_r;

  logic              accept, tick;
  logic [ROW_W-1:0]  rsat, down_row, left_row;
  logic [COL_W-1:0]  csat, left_col;
  logic              down_scroll;
  logic [7:0]        count_inc;
  logic              do_scroll, do_clear, do_read, wrote;
  logic              cmd_char_we, cmd_color_we;
  logic [ADDR_W-1:0] cmd_addr;
  logic [7:0]        cmd_char;

  logic              char_we, color_we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        char_wdata, color_wdata, char_rdata, color_rdata;

  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Argument saturation and neighbouring cursor positions
  assign tick        = in_data.is_tick || (in_data.op == OP_TICK);
  assign rsat        = (in_data.row_arg > LAST_ROW) ? LAST_ROW : in_data.row_arg;
  assign csat        = (in_data.col_arg > LAST_COL) ? LAST_COL : in_data.col_arg;
  assign down_scroll = (cur_row_r == LAST_ROW);
  assign down_row    = down_scroll ? LAST_ROW : cur_row_r + 1'b1;
  assign count_inc   = count_r + 8'd1;

  always_comb begin
    if (cur_col_r != '0) begin
      left_row = cur_row_r;
      left_col = cur_col_r - 1'b1;
    end else if (cur_row_r != '0) begin
      left_row = cur_row_r - 1'b1;
      left_col = LAST_COL;
    end else begin
      left_row = '0;
      left_col = '0;
    end
  end

  // Command decode: cursor, colour, blink and the cell write it causes
  always_comb begin
    row_nxt      = cur_row_r;
    col_nxt      = cur_col_r;
    color_nxt    = color_r;
    blink_nxt    = blink_r;
    count_nxt    = count_r;
    do_scroll    = 1'b0;
    do_clear     = 1'b0;
    do_read      = 1'b0;
    wrote        = 1'b0;
    cmd_char_we  = 1'b0;
    cmd_color_we = 1'b0;
    cmd_addr     = cell_addr(cur_row_r, cur_col_r);
    cmd_char     = in_data.char_code;
    if (tick) begin
      if (count_inc >= period_r) begin
        count_nxt = '0;
        blink_nxt = !blink_r;
      end else begin
        count_nxt = count_inc;
      end
    end else begin
      unique case (in_data.op)
        OP_PRINT: begin
          if (in_data.char_code == NEWLINE) begin
            col_nxt   = '0;
            row_nxt   = down_row;
            do_scroll = down_scroll;
          end else if (in_data.char_code >= ESC_LO && in_data.char_code <= ESC_HI) begin
            color_nxt = in_data.char_code - ESC_LO;
          end else begin
            cmd_char_we  = 1'b1;
            cmd_color_we = 1'b1;
            wrote        = 1'b1;
            if (cur_col_r == LAST_COL) begin
              col_nxt   = '0;
              row_nxt   = down_row;
              do_scroll = down_scroll;
            end else begin
              col_nxt = cur_col_r + 1'b1;
            end
          end
        end
        OP_LEFT: begin
          row_nxt = left_row;
          col_nxt = left_col;
        end
        OP_RIGHT: begin
          if (cur_col_r == LAST_COL) begin
            col_nxt   = '0;
            row_nxt   = down_row;
            do_scroll = down_scroll;
          end else begin
            col_nxt = cur_col_r + 1'b1;
          end
        end
        OP_UP: begin
          if (cur_row_r != '0) row_nxt = cur_row_r - 1'b1;
        end
        OP_DOWN: begin
          row_nxt   = down_row;
          do_scroll = down_scroll;
        end
        OP_SET: begin
          row_nxt = rsat;
          col_nxt = csat;
        end
        OP_DELETE: begin
          row_nxt     = left_row;
          col_nxt     = left_col;
          cmd_char_we = 1'b1;
          cmd_addr    = cell_addr(left_row, left_col);
          cmd_char    = BLANK;
        end
        OP_CLEAR: begin
          row_nxt  = '0;
          col_nxt  = '0;
          do_clear = 1'b1;
        end
        OP_READ: do_read = 1'b1;
        default: ;
      endcase
    end
  end

  // RAM port steering: command write, clearing sweep or scroll copy
  always_comb begin
    char_we     = 1'b0;
    color_we    = 1'b0;
    waddr       = wa_r;
    char_wdata  = BLANK;
    color_wdata = BLANK;
    raddr       = cell_addr(rsat, csat);
    case (state_r)
      ST_IDLE: begin
        char_we     = accept && cmd_char_we;
        color_we    = accept && cmd_color_we;
        waddr       = cmd_addr;
        char_wdata  = cmd_char;
        color_wdata = color_r;
      end
      ST_CLEAR: begin
        char_we  = 1'b1;
        color_we = 1'b1;
        waddr    = idx_r;
      end
      ST_SCROLL, ST_DRAIN: begin
        raddr       = idx_r + ROW_STRIDE;
        char_we     = wv_r;
        color_we    = wv_r;
        char_wdata  = wblank_r ? BLANK : char_rdata;
        color_wdata = wblank_r ? BLANK : color_rdata;
      end
      default: ;
    endcase
  end

  tmtb_ram #(.WIDTH(8), .DEPTH(CELLS)) u_char_ram (
    .clk   (clk),
    .we    (char_we),
    .waddr (waddr),
    .wdata (char_wdata),
    .raddr (raddr),
    .rdata (char_rdata)
  );

  tmtb_ram #(.WIDTH(8), .DEPTH(CELLS)) u_color_ram (
    .clk   (clk),
    .we    (color_we),
    .waddr (waddr),
    .wdata (color_wdata),
    .raddr (raddr),
    .rdata (color_rdata)
  );

  // Sequencer, cursor state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      wv_r        <= 1'b0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      color_r     <= COLOR_RESET;
      blink_r     <= 1'b0;
      count_r     <= '0;
      period_r    <= PERIOD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) period_r <= cfg_wdata;

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            cur_row_r <= row_nxt;
            cur_col_r <= col_nxt;
            color_r   <= color_nxt;
            blink_r   <= blink_nxt;
            count_r   <= count_nxt;
            if (do_clear) begin
              state_r <= ST_CLEAR;
              idx_r   <= '0;
            end else if (do_scroll) begin
              state_r <= ST_SCROLL;
              idx_r   <= '0;
            end else if (do_read) begin
              state_r <= ST_RD;
            end
          end
        end
        ST_RD: state_r <= ST_IDLE;
        ST_SCROLL: begin
          wa_r     <= idx_r;
          wv_r     <= 1'b1;
          wblank_r <= (idx_r >= SHIFT_CELLS);
          if (idx_r == LAST_CELL) begin
            state_r <= ST_DRAIN;
            idx_r   <= '0;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          wv_r    <= 1'b0;
          state_r <= ST_IDLE;
        end
        ST_CLEAR: begin
          if (idx_r == LAST_CELL) begin
            state_r <= ST_IDLE;
            idx_r   <= '0;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      // Result register: read-cell fills its data from the RAM read port in the ST_RD state
      if (accept) begin
        out_valid_r <= !do_read;
      end else if (state_r == ST_RD) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r.cell_char  <= '0;
      out_data_r.cell_color <= '0;
      out_data_r.cursor_row <= row_nxt;
      out_data_r.cursor_col <= col_nxt;
      out_data_r.blink_on   <= blink_nxt;
      out_data_r.wrote_cell <= wrote;
    end else if (state_r == ST_RD) begin
      out_data_r.cell_char  <= char_rdata;
      out_data_r.cell_color <= color_rdata;
    end
  end

  // Checks
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !tick && in_data.op == OP_READ) |=> (state_r == ST_RD && !out_valid_r)
    ##1 out_valid_r)
    else $error("read-cell result not delivered two cycles after its request");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_row_r <= LAST_ROW) && (cur_col_r <= LAST_COL))
    else $error("cursor outside the screen");

  a_scroll_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCROLL && wv_r) |-> (ADDR_W'(wa_r + 1'b1) == idx_r))
    else $error("scroll write not one cell behind its read");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && do_scroll) |=> (cur_row_r == LAST_ROW && state_r == ST_SCROLL))
    else $error("scroll started without cursor on the last row");

endmodule
